@@ rtl/core/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg
// shared types and codes of the totient table sieve
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

   localparam int unsigned MAX_N = 65535;

   localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

   localparam logic OP_BUILD  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

   typedef enum logic [1:0] {
      RD_I,
      RD_J,
      RD_IDX
   } rd_sel_type;

   typedef enum logic {
      WR_K,
      WR_J
   } wr_sel_type;

   typedef struct packed {
      logic       idx_load;
      logic       k_clr;
      logic       i_set;
      logic       i_inc;
      logic       j_set;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       div_start;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       rsp_load;
      logic [1:0] rsp_code;
      logic       rsp_data;
   } cmd_type;

   typedef struct packed {
      logic k_last;
      logic i_over;
      logic j_over;
      logic prime;
      logic div_done;
      logic idx_over;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/core/totient_table_sieve.sv @@
// lookup: ST_LK_CHK checks the index, ST_LK_WAIT loads the registered store read into
//    the result register, a status error straight from ST_LK_CHK; one request at a time
// build: ST_INIT writes k to each entry 0..L, then for each prime i <= L every
//    multiple j gets v - v/i, with v/i from the divider in ST_DIV
// reset clears control, sets limit to 65535 and marks the table not built;
//    the store itself is not cleared
// ----------------------------------------------------------------------------
// totient_table_sieve
// euler totient table built with a sieve, with single-entry lookups
// ----------------------------------------------------------------------------
`default_nettype none

module totient_table_sieve import tts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // index
   input  wire logic [0:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // totient
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata    // limit
);

   cmd_type  cmd;
   stat_type stat;

   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[0]),
      .csr_we     (csr_we),
      .stat       (stat),
      .cmd        (cmd)
   );

   tts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_index   (req_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_totient (rsp_tdata),
      .rsp_status  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ rtl/core/tts_div.sv @@
// ----------------------------------------------------------------------------
// tts_div
// 16-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tts_div import tts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[15]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'hF) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/core/tts_datapath.sv @@
// ----------------------------------------------------------------------------
// tts_datapath
// totient store, sieve counters, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tts_datapath import tts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [15:0] req_index,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_totient,
   output logic [1:0]       rsp_status
);

   logic [15:0] mem [0:65535];

   logic [15:0] lim_ff;
   logic [15:0] lim_eff;
   logic [15:0] idx_ff;
   logic [15:0] k_ff;
   logic [16:0] i_ff;
   logic [16:0] j_ff;
   logic [15:0] v_ff;
   logic [15:0] rd_data_ff;
   logic [15:0] rd_addr;
   logic [15:0] wr_addr;
   logic [15:0] wr_data;
   logic        rsp_valid_ff;
   logic [15:0] rsp_totient_ff;
   logic [1:0]  rsp_status_ff;
   logic        div_done;
   logic [15:0] quotient;

   assign lim_eff = (32'(lim_ff) > MAX_N) ? MAX_N[15:0] : lim_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_I:    rd_addr = i_ff[15:0];
         RD_J:    rd_addr = j_ff[15:0];
         RD_IDX:  rd_addr = idx_ff;
         default: rd_addr = idx_ff;
      endcase
      if (cmd.wr_sel == WR_K) begin
         wr_addr = k_ff;
         wr_data = k_ff;
      end else begin
         wr_addr = j_ff[15:0];
         wr_data = v_ff - quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_load) begin
         idx_ff <= req_index;
      end
      if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.wr_en && cmd.wr_sel == WR_K) begin
         k_ff <= k_ff + 16'd1;
      end
      if (cmd.i_set) begin
         i_ff <= 17'd2;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + 17'd1;
      end
      if (cmd.j_set) begin
         j_ff <= i_ff;
      end else if (cmd.wr_en && cmd.wr_sel == WR_J) begin
         j_ff <= j_ff + i_ff;
      end
      if (cmd.div_start) begin
         v_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_code;
         rsp_totient_ff <= cmd.rsp_data ? rd_data_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff       <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            lim_ff <= csr_wdata;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   tts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (i_ff[15:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      stat.k_last   = (k_ff == lim_eff);
      stat.i_over   = (i_ff > {1'b0, lim_eff});
      stat.j_over   = (j_ff > {1'b0, lim_eff});
      stat.prime    = (rd_data_ff == i_ff[15:0]);
      stat.div_done = div_done;
      stat.idx_over = (idx_ff > lim_eff);
      stat.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/core/tts_ctrl.sv @@
// ----------------------------------------------------------------------------
// tts_ctrl
// sequencer for table build and lookups
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl import tts_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire logic     req_opcode,
   input  wire logic     csr_we,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_I_CHK,
      ST_I_WAIT,
      ST_J_RD,
      ST_J_WAIT,
      ST_DIV,
      ST_LK_CHK,
      ST_LK_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      built_ff, built_in;

   assign req_tready = (state_ff == ST_IDLE) && !stat.rsp_busy;

   always_comb begin
      state_in = state_ff;
      built_in = built_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.idx_load = 1'b1;
               if (req_opcode == OP_BUILD) begin
                  cmd.k_clr = 1'b1;
                  state_in  = ST_INIT;
               end else if (req_opcode == OP_LOOKUP) begin
                  state_in = ST_LK_CHK;
               end
            end
         end
         ST_INIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_K;
            if (stat.k_last) begin
               cmd.i_set = 1'b1;
               state_in  = ST_I_CHK;
            end
         end
         ST_I_CHK: begin
            if (stat.i_over) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_code = STATUS_OK;
               built_in     = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_I;
               state_in   = ST_I_WAIT;
            end
         end
         ST_I_WAIT: begin
            if (stat.prime) begin
               cmd.j_set = 1'b1;
               state_in  = ST_J_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = ST_I_CHK;
            end
         end
         ST_J_RD: begin
            if (stat.j_over) begin
               cmd.i_inc = 1'b1;
               state_in  = ST_I_CHK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_J;
               state_in   = ST_J_WAIT;
            end
         end
         ST_J_WAIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_J;
               state_in   = ST_J_RD;
            end
         end
         ST_LK_CHK: begin
            if (!built_ff) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_code = STATUS_NOT_BUILT;
               state_in     = ST_IDLE;
            end else if (stat.idx_over) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_code = STATUS_RANGE;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = ST_LK_WAIT;
            end
         end
         ST_LK_WAIT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_code = STATUS_OK;
            cmd.rsp_data = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         built_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tts_checker.sv @@
// ----------------------------------------------------------------------------
// tts_checker
// port-level checks of the totient table sieve
// ----------------------------------------------------------------------------
`default_nettype none

module tts_checker import tts_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        csr_we,
   input wire logic [15:0] csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == 16'd0)
      else $error("error result carries nonzero totient");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken while result register is held");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind totient_table_sieve tts_checker u_tts_checker (.*);

`default_nettype wire
